// ===== hw/rtl/cpd_pkg.sv =====
// Shared types, constants and helpers for the cycling power packet decoder.
package cpd_pkg;

    localparam int MAX_PACKET_BYTES  = 32;
    localparam int CADENCE_FRAC_BITS = 8;

    localparam int IDX_W    = $clog2(MAX_PACKET_BYTES + 1);
    localparam int NUM_W    = 32;                           // drev * 61440 fits in 32 bits
    localparam int DVD_W    = NUM_W + CADENCE_FRAC_BITS;
    localparam int DCNT_W   = $clog2(DVD_W + 1);

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_PACKET_BYTES);

    localparam logic [15:0] POWER_TIMEOUT_RST   = 16'd2500;
    localparam logic [15:0] CADENCE_TIMEOUT_RST = 16'd2500;
    localparam logic [7:0]  CADENCE_MIN_RST     = 8'd1;
    localparam logic [7:0]  CADENCE_MAX_RST     = 8'd200;

    // Configuration register indexes
    localparam logic [1:0] REG_POWER_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_CADENCE_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_CADENCE_MIN     = 2'd2;
    localparam logic [1:0] REG_CADENCE_MAX     = 2'd3;

    // Flag bits of the packet header
    localparam int FLAG_PEDAL_BAL = 0;
    localparam int FLAG_TORQUE    = 2;
    localparam int FLAG_WHEEL     = 4;
    localparam int FLAG_CRANK     = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DECIDE,
        ST_DIV,
        ST_FINISH
    } state_t;

    // Packet fields gathered by the byte parser
    typedef struct packed {
        logic [7:0]  flag_bits;
        logic [15:0] power_raw;
        logic [15:0] crank_rev_new;
        logic [15:0] crank_time_new;
        logic [15:0] crank_rev_prev;
        logic [15:0] crank_time_prev;
    } parse_t;

    function automatic logic [IDX_W-1:0] crank_offset(input logic [7:0] flags);
        logic [IDX_W-1:0] pos;
        pos = IDX_W'(4);
        if (flags[FLAG_PEDAL_BAL]) pos = pos + IDX_W'(1);
        if (flags[FLAG_TORQUE])    pos = pos + IDX_W'(2);
        if (flags[FLAG_WHEEL])     pos = pos + IDX_W'(6);
        return pos;
    endfunction

endpackage

// ===== hw/rtl/cpd_parser.sv =====
// Byte parser: tracks the position in a packet and captures the fields.
module cpd_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_fire,
    input  logic [7:0]           data_byte,
    input  logic                 packet_end,
    input  logic                 restore,
    output logic [cpd_pkg::IDX_W-1:0] count,
    output cpd_pkg::parse_t      fields
);
    import cpd_pkg::*;

    logic [IDX_W-1:0] byte_index_reg;
    logic [IDX_W-1:0] byte_index_next;
    parse_t           fields_reg;
    parse_t           fields_next;
    logic [IDX_W-1:0] cpos;
    logic [IDX_W-1:0] pos;

    assign pos    = byte_index_reg;
    assign cpos   = crank_offset(fields_reg.flag_bits);
    assign count  = (pos < IDX_MAX) ? pos + IDX_W'(1) : IDX_MAX;
    assign fields = fields_reg;

    always_comb
    begin
        fields_next     = fields_reg;
        byte_index_next = byte_index_reg;
        if (byte_fire)
        begin
            if (pos < IDX_MAX)
            begin
                if (pos == IDX_W'(0))
                begin
                    fields_next.flag_bits = data_byte;
                end
                else if (pos == IDX_W'(2))
                begin
                    fields_next.power_raw[7:0] = data_byte;
                end
                else if (pos == IDX_W'(3))
                begin
                    fields_next.power_raw[15:8] = data_byte;
                end
                else if (fields_reg.flag_bits[FLAG_CRANK])
                begin
                    if (pos == cpos)
                    begin
                        fields_next.crank_rev_prev     = fields_reg.crank_rev_new;
                        fields_next.crank_time_prev    = fields_reg.crank_time_new;
                        fields_next.crank_rev_new[7:0] = data_byte;
                    end
                    else if (pos == cpos + IDX_W'(1))
                    begin
                        fields_next.crank_rev_new[15:8] = data_byte;
                    end
                    else if (pos == cpos + IDX_W'(2))
                    begin
                        fields_next.crank_time_new[7:0] = data_byte;
                    end
                    else if (pos == cpos + IDX_W'(3))
                    begin
                        fields_next.crank_time_new[15:8] = data_byte;
                    end
                end
            end
            byte_index_next = packet_end ? '0 : count;
        end
        else if (restore)
        begin
            // incomplete crank fields: undo the sample shift
            fields_next.crank_rev_new  = fields_reg.crank_rev_prev;
            fields_next.crank_time_new = fields_reg.crank_time_prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            fields_reg     <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            fields_reg     <= fields_next;
        end
    end

endmodule

// ===== hw/rtl/cpd_div.sv =====
// Bit-serial restoring divider with a saturated 16-bit quotient.
module cpd_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cpd_pkg::DVD_W-1:0] dividend,
    input  logic [15:0]               divisor,
    output logic                      done,
    output logic [15:0]               quotient
);
    import cpd_pkg::*;

    logic [DCNT_W-1:0] cnt_reg;
    logic [DCNT_W-1:0] cnt_next;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVD_W-1:0]  dvd_next;
    logic [15:0]       rem_reg;
    logic [15:0]       rem_next;
    logic [15:0]       quo_reg;
    logic [15:0]       quo_next;
    logic [15:0]       dsr_reg;
    logic [15:0]       dsr_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              done_reg;
    logic              done_next;
    logic [16:0]       rem_shift;
    logic [16:0]       rem_diff;
    logic              qbit;

    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign qbit      = (rem_shift >= {1'b0, dsr_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        ovf_next  = ovf_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = DCNT_W'(DVD_W);
            dvd_next = dividend;
            dsr_next = divisor;
            rem_next = '0;
            quo_next = '0;
            ovf_next = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next = qbit ? rem_diff[15:0] : rem_shift[15:0];
            // any quotient bit above bit 15 saturates the result
            ovf_next = ovf_reg | quo_reg[15];
            quo_next = {quo_reg[14:0], qbit};
            cnt_next = cnt_reg - DCNT_W'(1);
            done_next = (cnt_reg == DCNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        ovf_reg <= ovf_next;
    end

    assign done     = done_reg;
    assign quotient = ovf_reg ? 16'hFFFF : quo_reg;

endmodule

// ===== hw/rtl/cycling_power_packet_decoder.sv =====
// Cycling power packet decoder: top level with control, power and cadence state. Non-final
// bytes are taken one per cycle while idle. A final byte passes ST_EVAL, ST_DECIDE (later
// crank sample), ST_DIV (cadence division, one quotient bit per cycle over 40 bits) and
// ST_FINISH, which loads the output register once free, so m_axis_tvalid and s_axis_tready
// rise. One packet end is processed at a time; the output register lets the next packet start
// meanwhile. Reset (rst_n, async, active low) restores config defaults and clears that state.
module cycling_power_packet_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] data_byte, [39:8] now_ms
    input  logic        s_axis_tlast,   // packet_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] power_watts, [16] power_valid,
                                        // [32:17] cadence_q8, [33] cadence_valid,
                                        // [34] packet_short, [39:35] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import cpd_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [15:0] power_timeout_reg;
    logic [15:0] cadence_timeout_reg;
    logic [7:0]  cadence_min_reg;
    logic [7:0]  cadence_max_reg;

    logic [15:0] power_value_reg;
    logic        power_seen_reg;
    logic [31:0] power_stamp_reg;
    logic [15:0] cadence_value_reg;
    logic        cadence_seen_reg;
    logic [31:0] cadence_stamp_reg;

    logic [31:0]      now_reg;
    logic [IDX_W-1:0] count_reg;
    logic             short_reg;
    logic [15:0]      drev_reg;
    logic [15:0]      dtime_reg;
    logic [NUM_W-1:0] num_reg;
    logic [23:0]      minp_reg;
    logic [23:0]      maxp_reg;

    logic        out_valid_reg;
    logic [34:0] out_reg;

    logic             in_fire;
    logic             restore;
    logic             div_start;
    logic             div_done;
    logic [15:0]      div_q;
    logic             out_load;
    logic [IDX_W-1:0] count;
    parse_t           pf;
    logic [IDX_W-1:0] cpos;
    logic             crank_on;
    logic             crank_ok;
    logic [15:0]      drev;
    logic [15:0]      dtime;
    logic             moving;
    logic             in_range;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    cpd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_fire  (in_fire),
        .data_byte  (s_axis_tdata[7:0]),
        .packet_end (s_axis_tlast),
        .restore    (restore),
        .count      (count),
        .fields     (pf)
    );

    cpd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({num_reg, {CADENCE_FRAC_BITS{1'b0}}}),
        .divisor  (dtime_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cpos     = crank_offset(pf.flag_bits);
    assign crank_on = pf.flag_bits[FLAG_CRANK];
    assign crank_ok = crank_on && ({1'b0, count_reg} >= {1'b0, cpos} + (IDX_W+1)'(4));
    assign drev     = pf.crank_rev_new - pf.crank_rev_prev;
    assign dtime    = pf.crank_time_new - pf.crank_time_prev;
    assign moving   = (drev_reg != '0) && (dtime_reg != '0);
    assign in_range = (num_reg > NUM_W'(minp_reg)) && (num_reg <= NUM_W'(maxp_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        restore       = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_fire && s_axis_tlast)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                restore    = crank_on && !crank_ok && (count_reg > cpos);
                state_next = (crank_ok && cadence_seen_reg) ? ST_DECIDE : ST_FINISH;
            end
            ST_DECIDE:
            begin
                if (moving && in_range)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                out_load = !out_valid_reg || m_axis_tready;
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_timeout_reg   <= POWER_TIMEOUT_RST;
            cadence_timeout_reg <= CADENCE_TIMEOUT_RST;
            cadence_min_reg     <= CADENCE_MIN_RST;
            cadence_max_reg     <= CADENCE_MAX_RST;
            power_value_reg     <= '0;
            power_seen_reg      <= 1'b0;
            power_stamp_reg     <= '0;
            cadence_value_reg   <= '0;
            cadence_seen_reg    <= 1'b0;
            cadence_stamp_reg   <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_POWER_TIMEOUT:   power_timeout_reg   <= cfg_data;
                    REG_CADENCE_TIMEOUT: cadence_timeout_reg <= cfg_data;
                    REG_CADENCE_MIN:     cadence_min_reg     <= cfg_data[7:0];
                    REG_CADENCE_MAX:     cadence_max_reg     <= cfg_data[7:0];
                    default:             ;
                endcase
            end

            case (state_reg)
                ST_EVAL:
                begin
                    if (count_reg >= IDX_W'(4))
                    begin
                        power_seen_reg <= 1'b1;
                        if (pf.power_raw != '0)
                        begin
                            power_value_reg <= pf.power_raw;
                            power_stamp_reg <= now_reg;
                        end
                        else if ((now_reg - power_stamp_reg) > 32'(power_timeout_reg))
                        begin
                            power_value_reg <= '0;
                        end
                    end
                    // first crank sample only primes the stored sample
                    if (crank_ok && !cadence_seen_reg)
                    begin
                        cadence_seen_reg  <= 1'b1;
                        cadence_value_reg <= '0;
                    end
                end
                ST_DECIDE:
                begin
                    if (moving)
                    begin
                        if (num_reg > NUM_W'(minp_reg))
                        begin
                            cadence_stamp_reg <= now_reg;
                        end
                    end
                    else if ((now_reg - cadence_stamp_reg) > 32'(cadence_timeout_reg))
                    begin
                        cadence_value_reg <= '0;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        cadence_value_reg <= div_q;
                    end
                end
                default:
                begin
                end
            endcase

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_fire && s_axis_tlast)
        begin
            now_reg   <= s_axis_tdata[39:8];
            count_reg <= count;
        end
        if (state_reg == ST_EVAL)
        begin
            short_reg <= crank_on ? ({1'b0, count_reg} < {1'b0, cpos} + (IDX_W+1)'(4))
                                  : (count_reg < cpos);
            drev_reg  <= drev;
            dtime_reg <= dtime;
            // drev * 61440 = drev * 65536 - drev * 4096
            num_reg   <= {drev, 16'h0000} - {4'h0, drev, 12'h000};
            minp_reg  <= 24'(cadence_min_reg) * 24'(dtime);
            maxp_reg  <= 24'(cadence_max_reg) * 24'(dtime);
        end
        if (out_load)
        begin
            out_reg <= {short_reg, cadence_seen_reg, cadence_value_reg,
                        power_seen_reg, power_value_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_reg};

endmodule

// ===== tb/cycling_power_packet_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the cycling power packet decoder stream interface.
module cycling_power_packet_decoder_tb;
    import cpd_pkg::*;

    localparam int unsigned RPM_SCALE      = 61440;
    localparam int          SETTLE_CYCLES  = 60;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          WATCHDOG_LIMIT = 4000;

    // One decoded reading, laid out as on m_axis_tdata[34:0]
    typedef struct packed {
        logic        cut_short;
        logic        cadence_ok;
        logic [15:0] cadence;
        logic        watts_ok;
        logic [15:0] watts;
    } reading_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = REG_POWER_TIMEOUT;
    logic [15:0] cfg_data      = '0;

    cycling_power_packet_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Decoder state mirror
    int unsigned byte_pos;
    logic [7:0]  hdr_flags;
    logic [15:0] power_field, rev_cur, evt_cur, rev_last, evt_last;
    logic [15:0] watts_held, cadence_held;
    bit          watts_seen, cadence_seen;
    logic [31:0] watts_stamp, cadence_stamp;
    logic [15:0] power_limit_ms, cadence_limit_ms;
    logic [7:0]  rpm_floor, rpm_ceiling;

    reading_t    readings_due[$];
    int          errors     = 0;
    int          bytes_sent = 0;
    int          idle_count = 0;
    logic [31:0] clock_ms   = 32'hFFFF_F000;
    logic [15:0] bike_revs  = 16'd0;
    logic [15:0] bike_evt   = 16'd0;
    bit          src_idle   = 1'b1;
    bit          sink_idle  = 1'b1;
    bit          hold_request = 1'b0;
    int          hold_left  = 0;
    int          sink_gap   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned crank_start(input logic [7:0] flags);
        return 4 + flags[FLAG_PEDAL_BAL] + 2 * flags[FLAG_TORQUE] + 6 * flags[FLAG_WHEEL];
    endfunction

    function automatic void model_reset();
        byte_pos         = 0;
        hdr_flags        = '0;
        power_field      = '0;
        rev_cur          = '0;
        evt_cur          = '0;
        rev_last         = '0;
        evt_last         = '0;
        watts_held       = '0;
        cadence_held     = '0;
        watts_seen       = 1'b0;
        cadence_seen     = 1'b0;
        watts_stamp      = '0;
        cadence_stamp    = '0;
        power_limit_ms   = POWER_TIMEOUT_RST;
        cadence_limit_ms = CADENCE_TIMEOUT_RST;
        rpm_floor        = CADENCE_MIN_RST;
        rpm_ceiling      = CADENCE_MAX_RST;
    endfunction

    function automatic void update_cadence(input logic [31:0] now);
        logic [15:0] drev, dtime;
        logic [63:0] num, q;
        if (!cadence_seen)
        begin
            // first crank sample only primes the previous values
            cadence_seen = 1'b1;
            cadence_held = '0;
            return;
        end
        drev  = rev_cur - rev_last;
        dtime = evt_cur - evt_last;
        if (drev != 0 && dtime != 0)
        begin
            num = 64'(drev) * 64'(RPM_SCALE);
            if (num > 64'(rpm_floor) * 64'(dtime))
            begin
                if (num <= 64'(rpm_ceiling) * 64'(dtime))
                begin
                    q = (num << CADENCE_FRAC_BITS) / 64'(dtime);
                    cadence_held = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
                end
                cadence_stamp = now;
            end
        end
        else if (now - cadence_stamp > 32'(cadence_limit_ms))
            cadence_held = '0;
    endfunction

    // Advances the mirror by one byte; returns 1 when the byte ends a packet.
    function automatic bit decode_byte(input logic [7:0] b, input bit last,
                                       input logic [31:0] now, output reading_t r);
        int unsigned cnt, cpos, need;
        bit          crank_on;
        r = '0;
        if (byte_pos < MAX_PACKET_BYTES)
        begin
            if (byte_pos == 0)
                hdr_flags = b;
            else if (byte_pos == 2)
                power_field[7:0] = b;
            else if (byte_pos == 3)
                power_field[15:8] = b;
            else if (hdr_flags[FLAG_CRANK])
            begin
                cpos = crank_start(hdr_flags);
                if (byte_pos == cpos)
                begin
                    rev_last     = rev_cur;
                    evt_last     = evt_cur;
                    rev_cur[7:0] = b;
                end
                else if (byte_pos == cpos + 1)
                    rev_cur[15:8] = b;
                else if (byte_pos == cpos + 2)
                    evt_cur[7:0] = b;
                else if (byte_pos == cpos + 3)
                    evt_cur[15:8] = b;
            end
            cnt = byte_pos + 1;
        end
        else
            cnt = MAX_PACKET_BYTES;
        byte_pos = cnt;
        if (!last)
            return 1'b0;

        cpos     = crank_start(hdr_flags);
        crank_on = hdr_flags[FLAG_CRANK];
        need     = crank_on ? cpos + 4 : cpos;

        if (cnt >= 4)
        begin
            watts_seen = 1'b1;
            if (power_field != 0)
            begin
                watts_held  = power_field;
                watts_stamp = now;
            end
            else if (now - watts_stamp > 32'(power_limit_ms))
                watts_held = '0;
        end

        if (crank_on && cnt >= cpos + 4)
            update_cadence(now);
        else if (crank_on && cnt > cpos)
        begin
            // partial crank fields: undo the sample shift
            rev_cur = rev_last;
            evt_cur = evt_last;
        end

        byte_pos     = 0;
        r.watts      = watts_held;
        r.watts_ok   = watts_seen;
        r.cadence    = cadence_held;
        r.cadence_ok = cadence_seen;
        r.cut_short  = (cnt < need);
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit last, input logic [31:0] now);
        int       gap;
        reading_t r;
        gap = (src_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, b};
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        bytes_sent++;
        if (decode_byte(b, last, now, r))
            readings_due.push_back(r);
    endtask

    task automatic send_packet(input logic [7:0] flags, input int len, input logic [15:0] watts,
                               input logic [15:0] revs, input logic [15:0] evt);
        logic [7:0]  pkt[$];
        int unsigned cpos;
        cpos = crank_start(flags);
        for (int i = 0; i < len; i++)
            pkt.push_back(8'($urandom_range(0, 255)));
        pkt[0] = flags;
        if (len > 2) pkt[2] = watts[7:0];
        if (len > 3) pkt[3] = watts[15:8];
        if (flags[FLAG_CRANK])
        begin
            if (len > cpos)     pkt[cpos]     = revs[7:0];
            if (len > cpos + 1) pkt[cpos + 1] = revs[15:8];
            if (len > cpos + 2) pkt[cpos + 2] = evt[7:0];
            if (len > cpos + 3) pkt[cpos + 3] = evt[15:8];
        end
        for (int i = 0; i < len; i++)
            send_byte(pkt[i], i == len - 1, (i == len - 1) ? clock_ms : $urandom());
        if ($urandom_range(0, 4) == 0)
            src_idle = ~src_idle;
    endtask

    task automatic random_packet();
        logic [7:0]  flags;
        logic [15:0] watts;
        int unsigned cpos, need, drev, dt, rpm;
        int          len, r;
        flags = 8'($urandom_range(0, 255));
        flags[FLAG_CRANK] = ($urandom_range(0, 3) != 0);
        cpos = crank_start(flags);
        need = flags[FLAG_CRANK] ? cpos + 4 : cpos;
        r = $urandom_range(0, 19);
        if (r < 2)
            len = $urandom_range(1, need - 1);
        else if (r < 3)
            len = $urandom_range(MAX_PACKET_BYTES - 2, MAX_PACKET_BYTES + 8);
        else
            len = need + $urandom_range(0, 2);

        r = $urandom_range(0, 9);
        if (r < 4)
            watts = 16'd0;
        else if (r < 5)
            watts = 16'hFFFF;
        else
            watts = 16'($urandom_range(1, 1500));

        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            // plausible pedaling, occasionally outside the rpm window
            drev = $urandom_range(1, 4);
            rpm  = $urandom_range(10, 260);
            dt   = drev * 1024 * 60 / rpm;
            if (dt > 65535) dt = 65535;
        end
        else if (r < 7)
        begin
            drev = 0;
            dt   = $urandom_range(0, 65535);
        end
        else if (r < 8)
        begin
            drev = $urandom_range(0, 65535);
            dt   = 0;
        end
        else
        begin
            drev = $urandom_range(0, 65535);
            dt   = $urandom_range(0, 65535);
        end
        bike_revs = bike_revs + 16'(drev);
        bike_evt  = bike_evt + 16'(dt);

        r = $urandom_range(0, 19);
        if (r == 1)
            clock_ms = clock_ms + $urandom_range(3000, 80000);
        else if (r == 2)
            clock_ms = $urandom();
        else if (r > 2)
            clock_ms = clock_ms + $urandom_range(1, 2000);

        send_packet(flags, len, watts, bike_revs, bike_evt);
    endtask

    task automatic random_stream(input int n);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n)
            random_packet();
    endtask

    // Stop offering input and let every outstanding reading arrive.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [15:0] p_to, input logic [15:0] c_to,
                              input logic [7:0] lo_rpm, input logic [7:0] hi_rpm);
        logic [1:0]  idx[4];
        logic [15:0] val[4];
        idx = '{REG_POWER_TIMEOUT, REG_CADENCE_TIMEOUT, REG_CADENCE_MIN, REG_CADENCE_MAX};
        val = '{p_to, c_to, {8'h00, lo_rpm}, {8'h00, hi_rpm}};
        drain();
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            case (idx[i])
                REG_POWER_TIMEOUT:   power_limit_ms   = val[i];
                REG_CADENCE_TIMEOUT: cadence_limit_ms = val[i];
                REG_CADENCE_MIN:     rpm_floor        = val[i][7:0];
                REG_CADENCE_MAX:     rpm_ceiling      = val[i][7:0];
                default:             ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        // lone flags byte: too short for power
        send_packet(8'h00, 1, 16'd0, 16'd0, 16'd0);
        // full-scale power, first crank sample primes
        clock_ms = clock_ms + 500;
        send_packet(8'h20, 8, 16'hFFFF, 16'd100, 16'd1000);
        // two revs in one second: 120 rpm, zero power held
        clock_ms = clock_ms + 1000;
        send_packet(8'h20, 8, 16'd0, 16'd102, 16'd2024);
        // crank fields cut off after the first byte
        clock_ms = clock_ms + 500;
        send_packet(8'h20, 5, 16'd1, 16'd7, 16'd7);
        // unchanged crank and zero power past both timeouts, across the time wrap
        clock_ms = clock_ms + 3000;
        send_packet(8'h20, 8, 16'd0, 16'd102, 16'd2024);
        bike_revs = 16'd102;
        bike_evt  = 16'd2024;
    endtask

    task automatic test_config_sweep();
        write_regs(16'd0, 16'd0, 8'd0, 8'd255);
        random_stream(70);
        // minimum above maximum: no cadence can be taken
        write_regs(16'hFFFF, 16'hFFFF, 8'd255, 8'd1);
        random_stream(70);
        write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 60)), 8'($urandom_range(100, 255)));
        random_stream(70);
    endtask

    task automatic test_output_stall();
        src_idle     = 1'b0;
        hold_request = 1'b1;
        repeat (16)
        begin
            clock_ms = clock_ms + $urandom_range(0, 3000);
            send_packet(8'h00, 4, 16'($urandom_range(0, 65535)), 16'd0, 16'd0);
        end
    endtask

    task automatic test_random_traffic();
        write_regs(16'd1000, 16'd1500, 8'd5, 8'd180);
        random_stream(200);
    endtask

    initial
    begin
        model_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_sweep();
        test_output_stall();
        test_random_traffic();
        drain();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result sink with random stalls and one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if ($urandom_range(0, 149) == 0)
                sink_idle = ~sink_idle;
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (sink_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_gap--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (sink_idle && $urandom_range(0, 3) == 0)
                    sink_gap = pick_gap();
            end
        end
    end

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        reading_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = reading_t'(m_axis_tdata[34:0]);
            if (readings_due.size() == 0)
            begin
                $error("unexpected reading: tdata %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = readings_due.pop_front();
                compare_field("power_watts", want.watts, got.watts);
                compare_field("power_valid", 16'(want.watts_ok), 16'(got.watts_ok));
                compare_field("cadence_q8", want.cadence, got.cadence);
                compare_field("cadence_valid", 16'(want.cadence_ok), 16'(got.cadence_ok));
                compare_field("packet_short", 16'(want.cut_short), 16'(got.cut_short));
            end
        end
    end

    // Ends the run if no request moves on any channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule

// ===== cycling_power_packet_decoder.f =====
hw/rtl/cpd_pkg.sv
hw/rtl/cpd_parser.sv
hw/rtl/cpd_div.sv
hw/rtl/cycling_power_packet_decoder.sv
tb/cycling_power_packet_decoder_tb.sv
